### rtl/mvv_pkg.sv
// ============================================================================
// mvv_pkg
// Shared types, constants and fixed-point helpers for the modified
// velocity-Verlet particle update.
// ============================================================================
package mvv_pkg;

    // estimate store depth, one entry per particle slot (power of two)
    localparam int SLOT_COUNT = 1024;
    localparam int SLOT_AW    = $clog2(SLOT_COUNT);

    // dtfm quotient width and the zero padding below half_step_scale
    localparam int DTFM_W    = 56;
    localparam int DVD_SHIFT = 24;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // back-end intermediate widths
    localparam int DV_W  = 55;   // kick magnitude
    localparam int MHL_W = 39;   // upper kick bits times lambda
    localparam int MLL_W = 48;   // lower kick bits times lambda
    localparam int MIX_W = 59;   // mixed kick magnitude
    localparam int ADV_W = 40;   // position step magnitude

    // phase codes
    localparam logic MODE_FIRST = 1'b0;
    localparam logic MODE_FINAL = 1'b1;

    // register indexes on the configuration port
    localparam logic [1:0] REG_TIME_STEP  = 2'd0;
    localparam logic [1:0] REG_HALF_STEP  = 2'd1;
    localparam logic [1:0] REG_LAMBDA     = 2'd2;

    // reset values of the configuration registers
    localparam logic [31:0] TIME_STEP_RST = 32'd167772;
    localparam logic [31:0] HALF_STEP_RST = 32'd83886;
    localparam logic [15:0] LAMBDA_RST    = 16'd8192;

    typedef logic signed [31:0] word_t;
    typedef word_t [2:0] vec3_t;

    typedef struct packed {
        logic        mode;
        logic [9:0]  slot;
        logic [31:0] particle_mass;
        word_t       pos_x;
        word_t       pos_y;
        word_t       pos_z;
        word_t       vel_x;
        word_t       vel_y;
        word_t       vel_z;
        word_t       force_x;
        word_t       force_y;
        word_t       force_z;
    } in_t;

    typedef struct packed {
        logic [9:0] slot_out;
        word_t      new_pos_x;
        word_t      new_pos_y;
        word_t      new_pos_z;
        word_t      new_vel_x;
        word_t      new_vel_y;
        word_t      new_vel_z;
        logic       saturated;
    } out_t;

    // request as it travels through the divider stages
    typedef struct packed {
        logic              mode;
        logic [9:0]        slot;
        logic [31:0]       mass;
        logic [31:0]       hss;
        vec3_t             pos;
        vec3_t             vel;
        logic [2:0]        fneg;
        logic [2:0][31:0]  fmag;
    } carry_t;

    // classified request handed from front to back
    typedef struct packed {
        logic              mode;
        logic [9:0]        slot;
        vec3_t             pos;
        vec3_t             vel;
        logic [2:0]        fneg;
        logic [2:0][31:0]  fmag;
        logic [DTFM_W-1:0] dtfm;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic  sat;
        word_t val;
    } sat_t;

    // sign extend a word to 64 bits
    function automatic logic signed [63:0] sx64(input word_t v);
        return $signed({{32{v[31]}}, v});
    endfunction

    // attach a sign to a magnitude
    function automatic logic signed [63:0] sgn64(input logic [62:0] m, input logic neg);
        logic signed [63:0] p;
        p = $signed({1'b0, m});
        return neg ? -p : p;
    endfunction

    // clamp to the signed 32-bit range, flag when clamped
    function automatic sat_t sat32(input logic signed [63:0] s);
        sat_t r;
        if (s > 64'sh0000_0000_7FFF_FFFF)
        begin
            r.sat = 1'b1;
            r.val = 32'sh7FFF_FFFF;
        end
        else if (s < -64'sh0000_0000_8000_0000)
        begin
            r.sat = 1'b1;
            r.val = 32'sh8000_0000;
        end
        else
        begin
            r.sat = 1'b0;
            r.val = s[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/modified_velocity_verlet_step.sv
// ============================================================================
// modified_velocity_verlet_step
// Modified velocity-Verlet particle update in Q16.16 with an APB register
// port, a divider front, a short queue and an arithmetic back.
// ============================================================================
// One particle request is taken every clock cycle and one result leaves every
// cycle while the result side does not stall. The path runs through one input
// stage and 56 divider stages forming dtfm (one quotient bit per stage), one
// queue pass and five back stages. The estimate store (one 96-bit entry per
// slot) is written in the first phase and read in the final phase at the same
// back stage, so a final-phase request may follow its first-phase request
// directly. A final-phase read of a slot never written returns undefined
// velocity. Registers must be written only while the block is idle; the block
// itself does not enforce this.
module modified_velocity_verlet_step (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          item_valid,
    output logic          item_stall,
    input  mvv_pkg::in_t  item,
    output logic          result_valid,
    input  logic          result_stall,
    output mvv_pkg::out_t result
);

    logic [31:0]        time_step_reg;
    logic [31:0]        half_step_reg;
    logic [15:0]        lambda_reg;
    logic [1:0]         reg_idx;
    logic               push;
    logic               pop;
    mvv_pkg::work_t     push_item;
    mvv_pkg::work_t     head;
    mvv_pkg::q_status_t q_status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= mvv_pkg::TIME_STEP_RST;
            half_step_reg <= mvv_pkg::HALF_STEP_RST;
            lambda_reg    <= mvv_pkg::LAMBDA_RST;
        end
        else if (psel && penable && pwrite)
        begin
            if (reg_idx == mvv_pkg::REG_TIME_STEP)
            begin
                time_step_reg <= pwdata;
            end
            if (reg_idx == mvv_pkg::REG_HALF_STEP)
            begin
                half_step_reg <= pwdata;
            end
            if (reg_idx == mvv_pkg::REG_LAMBDA)
            begin
                lambda_reg <= pwdata[15:0];
            end
        end
    end

    // register reads
    always_comb
    begin
        unique case (reg_idx)
            mvv_pkg::REG_TIME_STEP: prdata = time_step_reg;
            mvv_pkg::REG_HALF_STEP: prdata = half_step_reg;
            mvv_pkg::REG_LAMBDA:    prdata = {16'b0, lambda_reg};
            default:                prdata = '0;
        endcase
    end

    // divider front
    mvv_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .half_step_scale (half_step_reg),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item            (item),
        .q_status        (q_status),
        .push            (push),
        .push_item       (push_item)
    );

    // decoupling queue
    mvv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // arithmetic back
    mvv_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .time_step     (time_step_reg),
        .lambda_factor (lambda_reg),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result)
    );

endmodule

### rtl/mvv_front.sv
// ============================================================================
// mvv_front
// Takes requests, splits forces into sign and magnitude and forms dtfm with a
// one-bit-per-stage restoring divider pipeline.
// ============================================================================
module mvv_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [31:0]        half_step_scale,
    input  logic               item_valid,
    output logic               item_stall,
    input  mvv_pkg::in_t       item,
    input  mvv_pkg::q_status_t q_status,
    output logic               push,
    output mvv_pkg::work_t     push_item
);

    localparam int LAST = mvv_pkg::DTFM_W;

    logic [LAST:0]              vld_reg;
    mvv_pkg::carry_t            carry_reg [LAST+1];
    logic [31:0]                rem_reg   [LAST+1];
    logic [mvv_pkg::DTFM_W-1:0] quo_reg   [LAST+1];
    logic                       adv;
    mvv_pkg::carry_t            in_carry;

    // whole pipeline moves unless the last stage cannot unload
    assign adv        = !(vld_reg[LAST] && q_status.full);
    assign item_stall = !adv;
    assign push       = adv && vld_reg[LAST];

    // classify the incoming request
    always_comb
    begin
        in_carry        = '0;
        in_carry.mode   = item.mode;
        in_carry.slot   = item.slot;
        in_carry.mass   = item.particle_mass;
        in_carry.hss    = half_step_scale;
        in_carry.pos[0] = item.pos_x;
        in_carry.pos[1] = item.pos_y;
        in_carry.pos[2] = item.pos_z;
        in_carry.vel[0] = item.vel_x;
        in_carry.vel[1] = item.vel_y;
        in_carry.vel[2] = item.vel_z;
        in_carry.fneg   = {item.force_z[31], item.force_y[31], item.force_x[31]};
        in_carry.fmag[0] = item.force_x[31] ? 32'(-item.force_x) : 32'(item.force_x);
        in_carry.fmag[1] = item.force_y[31] ? 32'(-item.force_y) : 32'(item.force_y);
        in_carry.fmag[2] = item.force_z[31] ? 32'(-item.force_z) : 32'(item.force_z);
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAST-1:0], item_valid};
        end
    end

    // input stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            carry_reg[0] <= in_carry;
            rem_reg[0]   <= '0;
            quo_reg[0]   <= '0;
        end
    end

    // divider stages, one quotient bit each, msb first
    for (genvar g = 1; g <= LAST; g++)
    begin : g_div
        logic        dvd_bit;
        logic [32:0] sh;
        logic [32:0] diff;
        logic        ge;

        if (mvv_pkg::DTFM_W - g >= mvv_pkg::DVD_SHIFT)
        begin : g_hss
            assign dvd_bit = carry_reg[g-1].hss[mvv_pkg::DTFM_W - g - mvv_pkg::DVD_SHIFT];
        end
        else
        begin : g_pad
            assign dvd_bit = 1'b0;
        end

        assign sh   = {rem_reg[g-1], dvd_bit};
        assign ge   = (sh >= {1'b0, carry_reg[g-1].mass});
        assign diff = sh - {1'b0, carry_reg[g-1].mass};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                carry_reg[g] <= carry_reg[g-1];
                rem_reg[g]   <= ge ? diff[31:0] : sh[31:0];
                quo_reg[g]   <= {quo_reg[g-1][mvv_pkg::DTFM_W-2:0], ge};
            end
        end
    end

    // hand-off to the queue
    always_comb
    begin
        push_item      = '0;
        push_item.mode = carry_reg[LAST].mode;
        push_item.slot = carry_reg[LAST].slot;
        push_item.pos  = carry_reg[LAST].pos;
        push_item.vel  = carry_reg[LAST].vel;
        push_item.fneg = carry_reg[LAST].fneg;
        push_item.fmag = carry_reg[LAST].fmag;
        push_item.dtfm = quo_reg[LAST];
    end

endmodule

### rtl/mvv_queue.sv
// ============================================================================
// mvv_queue
// Short FIFO decoupling the divider front from the arithmetic back.
// ============================================================================
module mvv_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mvv_pkg::work_t     push_item,
    input  logic               pop,
    output mvv_pkg::work_t     head,
    output mvv_pkg::q_status_t status
);

    mvv_pkg::work_t                entry_reg [mvv_pkg::QUEUE_DEPTH];
    logic [mvv_pkg::QUEUE_AW-1:0]  wr_ptr_reg;
    logic [mvv_pkg::QUEUE_AW-1:0]  rd_ptr_reg;
    logic [mvv_pkg::QUEUE_AW:0]    count_reg;
    logic [mvv_pkg::QUEUE_AW:0]    count_next;

    assign status.full  = (count_reg == (mvv_pkg::QUEUE_AW+1)'(mvv_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/mvv_back.sv
// ============================================================================
// mvv_back
// Kick, estimate store, mixing and position advance, ending in the result
// register.
// ============================================================================
module mvv_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [31:0]        time_step,
    input  logic [15:0]        lambda_factor,
    input  mvv_pkg::work_t     head,
    input  mvv_pkg::q_status_t q_status,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_stall,
    output mvv_pkg::out_t      result
);

    logic adv;

    // stage 1: partial kick products
    logic                       b1_vld_reg;
    mvv_pkg::work_t             b1_item_reg;
    logic [2:0][55:0]           b1_phi_reg;
    logic [2:0][63:0]           b1_plo_reg;
    logic [2:0][55:0]           phi_c;
    logic [2:0][63:0]           plo_c;

    // stage 2: kick magnitude
    logic                       b2_vld_reg;
    mvv_pkg::work_t             b2_item_reg;
    logic [2:0][mvv_pkg::DV_W-1:0] b2_dvm_reg;
    logic [2:0][mvv_pkg::DV_W-1:0] dvm_c;

    // stage 3: estimate, mixing products, stored estimate
    logic                       b3_vld_reg;
    mvv_pkg::work_t             b3_item_reg;
    mvv_pkg::vec3_t             b3_e_reg;
    logic                       b3_esat_reg;
    logic [2:0][mvv_pkg::DV_W-1:0]  b3_dvm_reg;
    logic [2:0][mvv_pkg::MHL_W-1:0] b3_mhl_reg;
    logic [2:0][mvv_pkg::MLL_W-1:0] b3_mll_reg;
    mvv_pkg::vec3_t             est_rd_reg;
    mvv_pkg::sat_t [2:0]        e_c;
    logic [2:0][mvv_pkg::MHL_W-1:0] mhl_c;
    logic [2:0][mvv_pkg::MLL_W-1:0] mll_c;
    logic                       est_we;
    mvv_pkg::vec3_t             est_mem [mvv_pkg::SLOT_COUNT];

    // stage 4: advance product, mixed kick, final-phase velocity
    logic                       b4_vld_reg;
    mvv_pkg::work_t             b4_item_reg;
    logic [2:0]                 b4_eneg_reg;
    logic                       b4_esat_reg;
    logic [2:0][63:0]           b4_advp_reg;
    logic [2:0][mvv_pkg::MIX_W-1:0] b4_mix_reg;
    mvv_pkg::vec3_t             b4_nv1_reg;
    logic                       b4_sat1_reg;
    logic [2:0][31:0]           emag_c;
    logic [2:0][63:0]           advp_c;
    logic [2:0][mvv_pkg::MIX_W-1:0] mix_c;
    mvv_pkg::sat_t [2:0]        nv1_c;

    // stage 5: result register
    logic                       out_vld_reg;
    mvv_pkg::out_t              out_reg;
    mvv_pkg::out_t              out_c;
    mvv_pkg::sat_t [2:0]        nx_c;
    mvv_pkg::sat_t [2:0]        nv0_c;

    // back pipeline moves unless the result waits
    assign adv          = !(out_vld_reg && result_stall);
    assign pop          = adv && !q_status.empty;
    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg  <= 1'b0;
            b2_vld_reg  <= 1'b0;
            b3_vld_reg  <= 1'b0;
            b4_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_vld_reg  <= !q_status.empty;
            b2_vld_reg  <= b1_vld_reg;
            b3_vld_reg  <= b2_vld_reg;
            b4_vld_reg  <= b3_vld_reg;
            out_vld_reg <= b4_vld_reg;
        end
    end

    // dtfm times force magnitude, split in two halves
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            phi_c[k] = head.dtfm[55:32] * head.fmag[k];
            plo_c[k] = head.dtfm[31:0] * head.fmag[k];
        end
    end

    // kick magnitude
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dvm_c[k] = mvv_pkg::DV_W'(b1_phi_reg[k] + 56'(b1_plo_reg[k][63:32]));
        end
    end

    // estimate and mixing products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e_c[k]   = mvv_pkg::sat32(mvv_pkg::sx64(b2_item_reg.vel[k])
                       + mvv_pkg::sgn64(63'(b2_dvm_reg[k]), b2_item_reg.fneg[k]));
            mhl_c[k] = b2_dvm_reg[k][54:32] * lambda_factor;
            mll_c[k] = b2_dvm_reg[k][31:0] * lambda_factor;
        end
    end

    assign est_we = adv && b2_vld_reg && (b2_item_reg.mode == mvv_pkg::MODE_FIRST);

    // estimate store, written by the first phase, read by the final phase
    always_ff @(posedge clk)
    begin
        if (est_we)
        begin
            est_mem[b2_item_reg.slot[mvv_pkg::SLOT_AW-1:0]] <=
                {e_c[2].val, e_c[1].val, e_c[0].val};
        end
        if (adv)
        begin
            est_rd_reg <= est_mem[b2_item_reg.slot[mvv_pkg::SLOT_AW-1:0]];
        end
    end

    // advance product, mixed kick and final-phase velocity
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            emag_c[k] = b3_e_reg[k][31] ? 32'(-b3_e_reg[k]) : 32'(b3_e_reg[k]);
            advp_c[k] = time_step * emag_c[k];
            mix_c[k]  = mvv_pkg::MIX_W'({b3_mhl_reg[k], 19'b0})
                        + mvv_pkg::MIX_W'(b3_mll_reg[k] >> 13);
            nv1_c[k]  = mvv_pkg::sat32(mvv_pkg::sx64(est_rd_reg[k])
                        + mvv_pkg::sgn64(63'(b3_dvm_reg[k]), b3_item_reg.fneg[k]));
        end
    end

    // final sums and phase selection
    always_comb
    begin
        out_c          = '0;
        out_c.slot_out = b4_item_reg.slot;
        for (int k = 0; k < 3; k++)
        begin
            nx_c[k]  = mvv_pkg::sat32(mvv_pkg::sx64(b4_item_reg.pos[k])
                       + mvv_pkg::sgn64(63'(b4_advp_reg[k][63:24]), b4_eneg_reg[k]));
            nv0_c[k] = mvv_pkg::sat32(mvv_pkg::sx64(b4_item_reg.vel[k])
                       + mvv_pkg::sgn64(63'(b4_mix_reg[k]), b4_item_reg.fneg[k]));
        end
        if (b4_item_reg.mode == mvv_pkg::MODE_FIRST)
        begin
            out_c.new_pos_x = nx_c[0].val;
            out_c.new_pos_y = nx_c[1].val;
            out_c.new_pos_z = nx_c[2].val;
            out_c.new_vel_x = nv0_c[0].val;
            out_c.new_vel_y = nv0_c[1].val;
            out_c.new_vel_z = nv0_c[2].val;
            out_c.saturated = b4_esat_reg | nx_c[0].sat | nx_c[1].sat | nx_c[2].sat
                              | nv0_c[0].sat | nv0_c[1].sat | nv0_c[2].sat;
        end
        else
        begin
            out_c.new_pos_x = b4_item_reg.pos[0];
            out_c.new_pos_y = b4_item_reg.pos[1];
            out_c.new_pos_z = b4_item_reg.pos[2];
            out_c.new_vel_x = b4_nv1_reg[0];
            out_c.new_vel_y = b4_nv1_reg[1];
            out_c.new_vel_z = b4_nv1_reg[2];
            out_c.saturated = b4_sat1_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_item_reg <= head;
            b1_phi_reg  <= phi_c;
            b1_plo_reg  <= plo_c;

            b2_item_reg <= b1_item_reg;
            b2_dvm_reg  <= dvm_c;

            b3_item_reg <= b2_item_reg;
            b3_e_reg    <= {e_c[2].val, e_c[1].val, e_c[0].val};
            b3_esat_reg <= e_c[0].sat | e_c[1].sat | e_c[2].sat;
            b3_dvm_reg  <= b2_dvm_reg;
            b3_mhl_reg  <= mhl_c;
            b3_mll_reg  <= mll_c;

            b4_item_reg <= b3_item_reg;
            b4_eneg_reg <= {b3_e_reg[2][31], b3_e_reg[1][31], b3_e_reg[0][31]};
            b4_esat_reg <= b3_esat_reg;
            b4_advp_reg <= advp_c;
            b4_mix_reg  <= mix_c;
            b4_nv1_reg  <= {nv1_c[2].val, nv1_c[1].val, nv1_c[0].val};
            b4_sat1_reg <= nv1_c[0].sat | nv1_c[1].sat | nv1_c[2].sat;

            out_reg     <= out_c;
        end
    end

endmodule
